// ----- src/sha_pkg.sv -----
// Package: SHA-256 types, constants and round functions.
`default_nettype none
package sha_pkg;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [0:0] {
    ACT_ABSORB = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD2,
    ST_EMIT
  } back_state_e;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// ----- src/sha_queue.sv -----
// Module: small item queue between the front and back parts.
`default_nettype none
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_stall_o,
  input  wire sha_pkg::item_t wr_item_i,
  output logic                rd_valid_o,
  input  wire logic           rd_take_i,
  output sha_pkg::item_t      rd_item_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  sha_pkg::item_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          wr, rd;

  assign wr_stall_o = (cnt_q == (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_take_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule
`default_nettype wire

// ----- src/sha_core.sv -----
// Module: back part; block buffer, padding, 64-round compression, digest output.
`default_nettype none
module sha_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  output logic                item_take_o,
  input  wire sha_pkg::item_t item_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);
  sha_pkg::back_state_e state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [60:0] cnt_q;
  logic [5:0]  rnd_q;
  logic        fin_q, pad2_q;
  logic [2:0]  oidx_q;
  logic        ov_q;
  logic [31:0] t1, t2, wnew, s0, s1;
  logic [63:0] bitlen;
  logic        take, start, lastrnd;
  logic [5:0]  pos;
  logic [3:0]  wi;

  assign pos = cnt_q[5:0];
  assign wi  = pos[5:2];
  assign bitlen = {cnt_q, 3'b000};
  assign take = item_valid_i && (state_q == sha_pkg::ST_IDLE);
  assign item_take_o = take;
  assign lastrnd = (rnd_q == 6'd63);

  // message schedule on a 16-word shift line
  assign s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = s1 + w_q[9] + s0 + w_q[0];
  assign t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
            ^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha_pkg::ROUND_K[rnd_q] + w_q[0];
  assign t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
            ^ sha_pkg::rotr(v_q[0], 22)) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
            ^ (v_q[1] & v_q[2]));

  assign start = take && ((item_i.action == sha_pkg::ACT_FINISH) || (pos == 6'd63));

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pkg::ST_IDLE:  if (start) state_d = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (lastrnd) state_d = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (pad2_q) state_d = sha_pkg::ST_PAD2;
        else if (fin_q) state_d = sha_pkg::ST_EMIT;
        else state_d = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_PAD2:  state_d = sha_pkg::ST_ROUND;
      sha_pkg::ST_EMIT:
        if (ov_q && !out_stall_i && oidx_q == 3'd7) state_d = sha_pkg::ST_IDLE;
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      cnt_q <= '0; rnd_q <= '0; fin_q <= 1'b0; pad2_q <= 1'b0;
      oidx_q <= '0; ov_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::H_INIT[i];
    end else begin
      state_q <= state_d;
      case (state_q)
        sha_pkg::ST_IDLE: if (take) begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          if (item_i.action == sha_pkg::ACT_ABSORB) begin
            cnt_q <= cnt_q + 61'd1;
            fin_q <= 1'b0; pad2_q <= 1'b0;
          end else begin
            fin_q <= 1'b1;
            pad2_q <= (pos >= 6'd56);
          end
        end
        sha_pkg::ST_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
        end
        sha_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (fin_q && !pad2_q) begin
            ov_q <= 1'b1; oidx_q <= '0;
          end
        end
        sha_pkg::ST_PAD2: begin
          pad2_q <= 1'b0; rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
        end
        sha_pkg::ST_EMIT: if (ov_q && !out_stall_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            ov_q <= 1'b0; cnt_q <= '0; fin_q <= 1'b0;
            for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::H_INIT[i];
          end
        end
        default: ;
      endcase
    end
  end

  // block buffer: byte writes, padding, then shift during rounds
  always_ff @(posedge clk_i) begin
    if (state_q == sha_pkg::ST_IDLE && take) begin
      if (item_i.action == sha_pkg::ACT_ABSORB) begin
        case (pos[1:0])
          2'd0:    w_q[wi] <= {item_i.data_byte, 24'h0};
          2'd1:    w_q[wi][23:16] <= item_i.data_byte;
          2'd2:    w_q[wi][15:8] <= item_i.data_byte;
          default: w_q[wi][7:0] <= item_i.data_byte;
        endcase
      end else begin
        // clear the tail, leaving the length words to their own write
        for (int i = 0; i < 16; i++) begin
          if (4'(i) > wi && (pos >= 6'd56 || i < 14)) w_q[i] <= '0;
        end
        case (pos[1:0])
          2'd0:    w_q[wi] <= {sha_pkg::PAD_BYTE, 24'h0};
          2'd1:    w_q[wi][23:0] <= {sha_pkg::PAD_BYTE, 16'h0};
          2'd2:    w_q[wi][15:0] <= {sha_pkg::PAD_BYTE, 8'h0};
          default: w_q[wi][7:0] <= sha_pkg::PAD_BYTE;
        endcase
        if (pos < 6'd56) begin
          w_q[14] <= bitlen[63:32];
          w_q[15] <= bitlen[31:0];
        end
      end
    end else if (state_q == sha_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end else if (state_q == sha_pkg::ST_PAD2) begin
      for (int i = 0; i < 14; i++) w_q[i] <= '0;
      w_q[14] <= bitlen[63:32];
      w_q[15] <= bitlen[31:0];
    end
  end

  assign out_valid_o   = ov_q;
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);
endmodule
`default_nettype wire

// ----- src/sha256_stream_hash.sv -----
// Top level: SHA-256 byte-stream hasher with item queue and compression core.
// Each absorb item loads one byte; the 64th byte of a block starts the
// compression core, which runs its rounds and then folds the result into the
// hash words, and takes no new item until it is idle again. A finish item
// pads, runs one or two compressions (two when 56 or more bytes sit in the
// last block), then emits eight digest items, index 0 first, one per cycle
// while out_stall_i is low. Hash state then returns to the initial values.
// A two-item queue takes input items while the core is busy.
`default_nettype none
module sha256_stream_hash #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  sha_pkg::item_t in_item, q_item;
  logic q_valid, q_take;

  // classify the item into its action code
  assign in_item = '{action: sha_pkg::action_e'(action_i), data_byte: data_byte_i};

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(in_valid_i), .wr_stall_o(in_stall_o), .wr_item_i(in_item),
    .rd_valid_o(q_valid), .rd_take_i(q_take), .rd_item_o(q_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .item_valid_i(q_valid), .item_take_o(q_take), .item_i(q_item),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

  // hold a stalled digest word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_index_o)
      && $stable(digest_word_o)) else $error("digest item changed under stall");
  // last flag only on index seven
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last flag misplaced");
  // advance index by one after each delivered word but the last
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o
      && word_index_o == $past(word_index_o) + 3'd1) else $error("index skip");
endmodule
`default_nettype wire

// ----- bench/sha256_stream_hash_checker.sv -----
// Checker: watches both channels, predicts SHA-256 digests and compares them.
module sha256_stream_hash_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          digest_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  chain [8];
  logic [31:0]  blk [16];
  logic [60:0]  byte_cnt;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic put_byte(int pos, logic [7:0] b);
    if (pos % 4 == 0) blk[pos / 4] = {b, 24'h0};
    else blk[pos / 4] |= 32'(b) << (8 * (3 - pos % 4));
  endtask

  // Advance the hash state by one item; queue the digest on finish.
  task automatic hash_item(sha_pkg::action_e act, logic [7:0] b);
    int pos;
    logic [63:0] bits;
    digest_word_t d;
    pos = int'(byte_cnt[5:0]);
    if (act == sha_pkg::ACT_ABSORB) begin
      put_byte(pos, b);
      byte_cnt++;
      if (pos == 63) compress();
    end else begin
      bits = {byte_cnt, 3'b000};
      put_byte(pos, sha_pkg::PAD_BYTE);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = chain[i];
        d.index = 3'(i);
        d.last = (i == 7);
        digest_q.push_back(d);
      end
      for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
      byte_cnt = '0;
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    byte_cnt = '0;
    fail_count_o = 0;
    digest_count_o = 0;
  end

  assign pending_o = digest_q.size();

  always @(posedge clk_i) begin
    digest_word_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) hash_item(sha_pkg::action_e'(action_i), data_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", digest_word_i);
          fail_count_o++;
        end else begin
          e = digest_q.pop_front();
          digest_count_o++;
          if (digest_word_i !== e.word) begin
            $error("digest_word expected %h actual %h", e.word, digest_word_i);
            fail_count_o++;
          end
          if (word_index_i !== e.index) begin
            $error("word_index expected %0d actual %0d", e.index, word_index_i);
            fail_count_o++;
          end
          if (last_word_i !== e.last) begin
            $error("last_word expected %0d actual %0d", e.last, last_word_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ----- bench/sha256_stream_hash_tb.sv -----
// Testbench top: drives byte and finish items into the hasher and reports the verdict.
module sha256_stream_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        action_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o, out_valid_o, last_word_o;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  int          fail_count, pending, digest_count;
  int          idle_cycles = 0;
  int          items_sent = 0;
  int          msgs_sent = 0;
  bit          calm = 1'b0;

  sha256_stream_hash i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .data_byte_i,
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

  sha256_stream_hash_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .digest_word_i(digest_word_o),
    .word_index_i(word_index_o), .last_word_i(last_word_o),
    .fail_count_o(fail_count), .pending_o(pending), .digest_count_o(digest_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stall the digest side about 23% of cycles, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 23);
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired, %0d digest words pending", pending);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item, optionally after a random gap; hold it until accepted.
  // Stall is sampled mid-cycle, where it holds the value seen at the next edge.
  task automatic send_item(sha_pkg::action_e act, logic [7:0] b);
    bit stalled;
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= b;
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    items_sent++;
    if (act == sha_pkg::ACT_FINISH) msgs_sent++;
  endtask

  // Send a message of len bytes (pattern: 0 random, 1 all zero, 2 all ones), then finish.
  task automatic send_msg(int len, int pattern);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (pattern == 1) ? 8'h00 : (pattern == 2) ? 8'hff : 8'($urandom);
      send_item(sha_pkg::ACT_ABSORB, b);
    end
    send_item(sha_pkg::ACT_FINISH, 8'($urandom));
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, finish with a stray byte, extremes of the byte,
    // and a one-byte message.
    send_item(sha_pkg::ACT_FINISH, 8'h00);
    send_item(sha_pkg::ACT_FINISH, 8'hff);
    send_msg(3, 1);
    send_msg(4, 2);
    send_msg(1, 0);
    drop_valid();

    // Random messages; lengths straddle the one- and two-block padding cases,
    // full blocks and multi-block messages, with a calm stretch in the middle.
    // The last message is trimmed so the run ends near 210 items.
    while (items_sent < 210) begin
      calm = (items_sent >= 90 && items_sent < 150);
      case ($urandom_range(5))
        0: len = $urandom_range(54, 65);
        1: len = $urandom_range(0, 8);
        2: len = 64 * $urandom_range(1, 2);
        default: len = $urandom_range(0, 40);
      endcase
      if (len > 209 - items_sent) len = 209 - items_sent;
      send_msg(len, ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
      if ($urandom_range(3) == 0) drop_valid();
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("sent %0d items in %0d messages, checked %0d digest words",
             items_sent, msgs_sent, digest_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
